// File: hw/rtl/gspi_pkg.sv
// Shared constants and the Gaussian profile function for the spot pixel injector.
// No dependencies; used by the core, the profile ROM and the checker.
`timescale 1ns / 1ps

package gspi_pkg;

    // Default geometry and profile size
    localparam int WINDOW_RADIUS = 8;
    localparam int COORD_BITS    = 12;
    localparam int PROFILE_DEPTH = 4096;

    // Fixed-point formats
    localparam int FRAC_BITS = 8;    // sub-pixel bits of the centre
    localparam int VALUE_W   = 16;   // pixel value width
    localparam int PEAK_W    = 19;   // signed Q14.4 peak
    localparam int ENTRY_W   = 16;   // Q0.16 profile entry
    localparam int ACC_FRAC  = 20;   // fraction bits of the sum
    localparam int IDX_SHIFT = 12;   // Q.16 r^2 to 1/16 px^2 steps

    localparam logic [VALUE_W-1:0] MAX_LEVEL_RESET = 16'd1023;

    // exp(-1/81.92) in Q0.32
    localparam logic [63:0] PROFILE_STEP = 64'd4242857198;

    // Profile entry k = exp(-k/81.92), square-and-multiply in Q0.32 with
    // half-up rounding on every product, then rounded to Q0.16 and saturated.
    function automatic logic [ENTRY_W-1:0] profile_entry(input logic [31:0] k);
        logic [63:0]  val;
        logic [63:0]  base;
        logic [63:0]  e;
        logic [127:0] prod;
        val  = 64'd1 << 32;
        base = PROFILE_STEP;
        for (int b = 0; b < 16; b++) begin
            if (k[b]) begin
                prod = 128'(val) * 128'(base) + 128'h8000_0000;
                val  = prod[95:32];
            end
            prod = 128'(base) * 128'(base) + 128'h8000_0000;
            base = prod[95:32];
        end
        e = (val + 64'h8000) >> 16;
        return (e > 64'd65535) ? 16'hFFFF : e[ENTRY_W-1:0];
    endfunction

endpackage

// File: hw/rtl/gspi_profile_rom.sv
// Gaussian profile ROM: constant table built at elaboration, registered read.
// Depends on gspi_pkg for the entry function.
`timescale 1ns / 1ps

module gspi_profile_rom #(
    parameter int DEPTH = gspi_pkg::PROFILE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [gspi_pkg::ENTRY_W-1:0] rd_data
);

    logic [gspi_pkg::ENTRY_W-1:0] rom_w [DEPTH];
    logic [gspi_pkg::ENTRY_W-1:0] rd_data_reg;

    // Table contents
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        localparam logic [gspi_pkg::ENTRY_W-1:0] ENTRY = gspi_pkg::profile_entry(32'(k));
        assign rom_w[k] = ENTRY;
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom_w[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/gaussian_spot_pixel_injector_core.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------------
// input     | s_valid / s_ready    | s_pix_x, s_pix_y, s_pix_value, s_centre_x/y, s_peak_level
// result    | m_valid / m_ready    | m_out_value, m_in_window
// config    | cfg_valid / cfg_ready| cfg_data (max_level)
//
// Seven-stage pipeline: one transaction per cycle while the output is not stalled.
// The stage depth is set by the ROM read register and the multipliers, each followed by a
// register. Each stage holds only while it is full and the next cannot advance, so bubbles
// fill up under an output stall. Reset (synchronous, active low) clears the valid bits and
// sets max_level to 1023; the profile is a constant ROM, so no fill pass follows reset.
// Depends on gspi_pkg and gspi_profile_rom.
`timescale 1ns / 1ps

module gaussian_spot_pixel_injector_core #(
    parameter int WINDOW_RADIUS = gspi_pkg::WINDOW_RADIUS,
    parameter int COORD_BITS    = gspi_pkg::COORD_BITS,
    parameter int PROFILE_DEPTH = gspi_pkg::PROFILE_DEPTH
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // configuration
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [gspi_pkg::VALUE_W-1:0]                cfg_data,
    // input pixel
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [COORD_BITS-1:0]                       s_pix_x,
    input  logic [COORD_BITS-1:0]                       s_pix_y,
    input  logic [gspi_pkg::VALUE_W-1:0]                s_pix_value,
    input  logic [COORD_BITS+gspi_pkg::FRAC_BITS-1:0]   s_centre_x,
    input  logic [COORD_BITS+gspi_pkg::FRAC_BITS-1:0]   s_centre_y,
    input  logic signed [gspi_pkg::PEAK_W-1:0]          s_peak_level,
    // result pixel
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [gspi_pkg::VALUE_W-1:0]                m_out_value,
    output logic                                        m_in_window
);

    localparam int FRAC_BITS = gspi_pkg::FRAC_BITS;
    localparam int VALUE_W   = gspi_pkg::VALUE_W;
    localparam int PEAK_W    = gspi_pkg::PEAK_W;
    localparam int ENTRY_W   = gspi_pkg::ENTRY_W;
    localparam int ACC_FRAC  = gspi_pkg::ACC_FRAC;
    localparam int IDX_SHIFT = gspi_pkg::IDX_SHIFT;

    localparam int CENTRE_W = COORD_BITS + FRAC_BITS;
    localparam int WIN_W    = COORD_BITS + $clog2(WINDOW_RADIUS + 1) + 1;
    localparam int DIFF_W   = $clog2(((WINDOW_RADIUS + 1) << FRAC_BITS) + 1);
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int R2_W     = SQ_W + 1;
    localparam int IDX_W    = R2_W + 1 - IDX_SHIFT;
    localparam int ADDR_W   = $clog2(PROFILE_DEPTH);
    localparam int IDXX_W   = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
    localparam int PROD_W   = PEAK_W + ENTRY_W + 1;
    localparam int ACC_W    = VALUE_W + ACC_FRAC + 2;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0] max_level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= gspi_pkg::MAX_LEVEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_level_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Stage valid bits and per-stage advance
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

    assign adv7 = !v7_reg || m_ready;
    assign adv6 = !v6_reg || adv7;
    assign adv5 = !v5_reg || adv6;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_ready = adv1;
    assign m_valid = v7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: window test and absolute offsets from the centre
    // ---------------------------------------------------------------
    logic [COORD_BITS-1:0] cx_int, cy_int;
    logic                  win_x, win_y;
    logic [CENTRE_W-1:0]   ax, ay, dx_full, dy_full;
    logic [DIFF_W-1:0]     dx_next, dy_next;

    assign cx_int = s_centre_x[CENTRE_W-1:FRAC_BITS];
    assign cy_int = s_centre_y[CENTRE_W-1:FRAC_BITS];

    assign win_x = (WIN_W'(s_pix_x) + WIN_W'(WINDOW_RADIUS) >= WIN_W'(cx_int))
                && (WIN_W'(s_pix_x) <= WIN_W'(cx_int) + WIN_W'(WINDOW_RADIUS));
    assign win_y = (WIN_W'(s_pix_y) + WIN_W'(WINDOW_RADIUS) >= WIN_W'(cy_int))
                && (WIN_W'(s_pix_y) <= WIN_W'(cy_int) + WIN_W'(WINDOW_RADIUS));

    assign ax      = {s_pix_x, FRAC_BITS'(0)};
    assign ay      = {s_pix_y, FRAC_BITS'(0)};
    assign dx_full = (ax >= s_centre_x) ? (ax - s_centre_x) : (s_centre_x - ax);
    assign dy_full = (ay >= s_centre_y) ? (ay - s_centre_y) : (s_centre_y - ay);
    // inside the window the offset always fits DIFF_W
    assign dx_next = dx_full[DIFF_W-1:0];
    assign dy_next = dy_full[DIFF_W-1:0];

    logic [DIFF_W-1:0]         dx1_reg, dy1_reg;
    logic                      win1_reg;
    logic [VALUE_W-1:0]        pv1_reg;
    logic signed [PEAK_W-1:0]  pk1_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            win1_reg <= win_x && win_y;
            pv1_reg  <= s_pix_value;
            pk1_reg  <= s_peak_level;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: squares of the offsets (Q.16)
    // ---------------------------------------------------------------
    logic [SQ_W-1:0]           sqx2_reg, sqy2_reg;
    logic                      win2_reg;
    logic [VALUE_W-1:0]        pv2_reg;
    logic signed [PEAK_W-1:0]  pk2_reg;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            sqx2_reg <= SQ_W'(dx1_reg) * SQ_W'(dx1_reg);
            sqy2_reg <= SQ_W'(dy1_reg) * SQ_W'(dy1_reg);
            win2_reg <= win1_reg;
            pv2_reg  <= pv1_reg;
            pk2_reg  <= pk1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: r^2, rounded profile index, range check
    // ---------------------------------------------------------------
    logic [R2_W-1:0]   r2;
    logic [R2_W:0]     r2_rnd;
    logic [IDX_W-1:0]  idx;
    logic [IDXX_W-1:0] idx_ext;
    logic              in_range_next;
    logic [ADDR_W-1:0] addr_next;

    assign r2            = R2_W'(sqx2_reg) + R2_W'(sqy2_reg);
    assign r2_rnd        = (R2_W + 1)'(r2) + (R2_W + 1)'(1 << (IDX_SHIFT - 1));
    assign idx           = r2_rnd[R2_W:IDX_SHIFT];
    assign idx_ext       = IDXX_W'(idx);
    assign in_range_next = idx_ext < IDXX_W'(PROFILE_DEPTH);
    assign addr_next     = in_range_next ? idx_ext[ADDR_W-1:0] : '0;

    logic [ADDR_W-1:0]         addr3_reg;
    logic                      rng3_reg;
    logic                      win3_reg;
    logic [VALUE_W-1:0]        pv3_reg;
    logic signed [PEAK_W-1:0]  pk3_reg;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            addr3_reg <= addr_next;
            rng3_reg  <= in_range_next;
            win3_reg  <= win2_reg;
            pv3_reg   <= pv2_reg;
            pk3_reg   <= pk2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: profile lookup
    // ---------------------------------------------------------------
    logic [ENTRY_W-1:0] entry4;

    gspi_profile_rom #(
        .DEPTH   (PROFILE_DEPTH)
    ) u_profile_rom (
        .aclk    (aclk),
        .rd_en   (adv4),
        .rd_addr (addr3_reg),
        .rd_data (entry4)
    );

    logic                      rng4_reg;
    logic                      win4_reg;
    logic [VALUE_W-1:0]        pv4_reg;
    logic signed [PEAK_W-1:0]  pk4_reg;

    always_ff @(posedge aclk) begin
        if (adv4) begin
            rng4_reg <= rng3_reg;
            win4_reg <= win3_reg;
            pv4_reg  <= pv3_reg;
            pk4_reg  <= pk3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: peak times profile (beyond the table the spot adds zero)
    // ---------------------------------------------------------------
    logic [ENTRY_W-1:0]        entry_eff;
    logic signed [PROD_W-1:0]  prod_next;

    assign entry_eff = rng4_reg ? entry4 : '0;
    assign prod_next = pk4_reg * $signed({1'b0, entry_eff});

    logic signed [PROD_W-1:0]  prod5_reg;
    logic                      win5_reg;
    logic [VALUE_W-1:0]        pv5_reg;

    always_ff @(posedge aclk) begin
        if (adv5) begin
            prod5_reg <= prod_next;
            win5_reg  <= win4_reg;
            pv5_reg   <= pv4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: add to the pixel value in Q.20
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = $signed({2'b00, pv5_reg, ACC_FRAC'(0)}) + ACC_W'(prod5_reg);

    logic signed [ACC_W-1:0] acc6_reg;
    logic                    win6_reg;
    logic [VALUE_W-1:0]      pv6_reg;

    always_ff @(posedge aclk) begin
        if (adv6) begin
            acc6_reg <= acc_next;
            win6_reg <= win5_reg;
            pv6_reg  <= pv5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: pass-through outside the window, else saturate, clamp at zero, round half up
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] ceil_q20;
    logic signed [ACC_W-1:0] acc_rnd;
    logic                    over_ceil;
    logic [VALUE_W-1:0]      value_next;

    assign ceil_q20  = $signed({2'b00, max_level_reg, ACC_FRAC'(0)});
    assign acc_rnd   = acc6_reg + ACC_W'(1 << (ACC_FRAC - 1));
    assign over_ceil = acc6_reg > ceil_q20;

    always_comb begin
        if (!win6_reg) begin
            value_next = pv6_reg;
        end else if (over_ceil) begin
            value_next = max_level_reg;
        end else if (acc6_reg[ACC_W-1]) begin
            value_next = '0;
        end else begin
            value_next = acc_rnd[ACC_FRAC +: VALUE_W];
        end
    end

    logic [VALUE_W-1:0] out_value_reg;
    logic               in_window_reg;

    always_ff @(posedge aclk) begin
        if (adv7) begin
            out_value_reg <= value_next;
            in_window_reg <= win6_reg;
        end
    end

    assign m_out_value = out_value_reg;
    assign m_in_window = in_window_reg;

endmodule

// File: hw/rtl/gspi_checker.sv
// Port-level checks for the spot pixel injector core, bound into every core instance.
// Depends on gspi_pkg and gaussian_spot_pixel_injector_core.
`timescale 1ns / 1ps

module gspi_checker (
    input logic                                        aclk,
    input logic                                        aresetn,
    input logic                                        s_valid,
    input logic                                        s_ready,
    input logic                                        m_valid,
    input logic                                        m_ready,
    input logic [gspi_pkg::VALUE_W-1:0]                m_out_value,
    input logic                                        m_in_window
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_in_window))
        else $error("result changed while stalled");

    // a flowing output never back-pressures the input
    a_flow_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled although output is ready");

    // with no output stall an accepted transaction reaches the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
            ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("transaction missing at the pipeline output");

endmodule

bind gaussian_spot_pixel_injector_core gspi_checker u_gspi_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for gaussian_spot_pixel_injector_core: pixel transactions with
// star spots, max_level writes, random idling on both channels, an in-file spot predictor.
// Depends on gspi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CW          = gspi_pkg::COORD_BITS;
    localparam int FW          = gspi_pkg::COORD_BITS + gspi_pkg::FRAC_BITS;
    localparam int VW          = gspi_pkg::VALUE_W;
    localparam int PW          = gspi_pkg::PEAK_W;
    localparam int RADIUS      = gspi_pkg::WINDOW_RADIUS;
    localparam int LUT_DEPTH   = gspi_pkg::PROFILE_DEPTH;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 80;

    typedef struct {
        logic [CW-1:0]        px;
        logic [CW-1:0]        py;
        logic [VW-1:0]        pv;
        logic [FW-1:0]        cx;
        logic [FW-1:0]        cy;
        logic signed [PW-1:0] peak;
    } spot_pixel_t;

    typedef struct {
        logic [VW-1:0] value;
        logic          in_win;
    } injected_pixel_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [VW-1:0]        cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CW-1:0]        s_pix_x = '0;
    logic [CW-1:0]        s_pix_y = '0;
    logic [VW-1:0]        s_pix_value = '0;
    logic [FW-1:0]        s_centre_x = '0;
    logic [FW-1:0]        s_centre_y = '0;
    logic signed [PW-1:0] s_peak_level = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [VW-1:0]        m_out_value;
    logic                 m_in_window;

    spot_pixel_t     pixel_feed_q[$];
    injected_pixel_t predicted_px_q[$];
    logic [15:0]     psf_weight_lut[LUT_DEPTH];
    logic [VW-1:0]   ceiling_adu = gspi_pkg::MAX_LEVEL_RESET;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned inwin_cnt = 0;
    int unsigned setting_cnt = 1;

    gaussian_spot_pixel_injector_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pix_x      (s_pix_x),
        .s_pix_y      (s_pix_y),
        .s_pix_value  (s_pix_value),
        .s_centre_x   (s_centre_x),
        .s_centre_y   (s_centre_y),
        .s_peak_level (s_peak_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_in_window  (m_in_window)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // exp(-k/81.92) in Q0.16: powers of the Q0.32 step, half-up rounding on each product
    function automatic logic [15:0] psf_weight(int unsigned k);
        logic [63:0] prod_q32;
        logic [63:0] pow_q32;
        logic [63:0] q16;
        prod_q32 = 64'h1_0000_0000;
        pow_q32  = gspi_pkg::PROFILE_STEP;
        for (int b = 0; b < 16; b++) begin
            if (k[b])
                prod_q32 = (prod_q32 * pow_q32 + 64'h8000_0000) >> 32;
            pow_q32 = (pow_q32 * pow_q32 + 64'h8000_0000) >> 32;
        end
        q16 = (prod_q32 + 64'h8000) >> 16;
        return (q16 > 64'd65535) ? 16'hFFFF : q16[15:0];
    endfunction

    // Window test on one axis: centre cell +/- radius, lower edge stops at zero
    function automatic bit axis_in_spot(logic [CW-1:0] p, logic [FW-1:0] centre);
        int pc;
        int cc;
        pc = int'(p);
        cc = int'(centre >> gspi_pkg::FRAC_BITS);
        return (pc + RADIUS >= cc) && (pc <= cc + RADIUS);
    endfunction

    // Squared distance along one axis in Q.16
    function automatic longint axis_dist_sq(logic [CW-1:0] p, logic [FW-1:0] centre);
        longint d;
        d = (longint'(p) << gspi_pkg::FRAC_BITS) - longint'(centre);
        return d * d;
    endfunction

    // Expected output pixel for one input transaction at the current ceiling
    function automatic injected_pixel_t spot_pixel_after_inject(spot_pixel_t r);
        injected_pixel_t res;
        longint          r2;
        longint          idx;
        longint          weight;
        longint          acc;
        longint          ceil_q20;
        res.in_win = axis_in_spot(r.px, r.cx) && axis_in_spot(r.py, r.cy);
        if (!res.in_win) begin
            res.value = r.pv;
            return res;
        end
        r2     = axis_dist_sq(r.px, r.cx) + axis_dist_sq(r.py, r.cy);
        idx    = (r2 + 2048) >>> gspi_pkg::IDX_SHIFT;
        weight = (idx < LUT_DEPTH) ? longint'(psf_weight_lut[idx]) : 0;
        acc    = (longint'(r.pv) << gspi_pkg::ACC_FRAC) + longint'(r.peak) * weight;
        ceil_q20 = longint'(ceiling_adu) << gspi_pkg::ACC_FRAC;
        if (acc > ceil_q20)
            res.value = ceiling_adu;
        else if (acc < 0)
            res.value = '0;
        else
            res.value = VW'((acc + (longint'(1) << (gspi_pkg::ACC_FRAC - 1)))
                            >>> gspi_pkg::ACC_FRAC);
        return res;
    endfunction

    // Pixel driver: a new transaction goes out once the previous one is taken
    always @(posedge aclk) begin
        spot_pixel_t req;
        if (aresetn && (!s_valid || s_ready)) begin
            if (pixel_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pixel_feed_q.pop_front();
                // order of presentation is order of acceptance
                predicted_px_q.push_back(spot_pixel_after_inject(req));
                s_valid      <= 1'b1;
                s_pix_x      <= req.px;
                s_pix_y      <= req.py;
                s_pix_value  <= req.pv;
                s_centre_x   <= req.cx;
                s_centre_y   <= req.cy;
                s_peak_level <= req.peak;
                sent_cnt++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin
        injected_pixel_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_px_q.size() == 0) begin
                    $error("result transaction with nothing pending: out_value %0d, in_window %0d",
                           m_out_value, m_in_window);
                    err_cnt++;
                end else begin
                    want = predicted_px_q.pop_front();
                    if (m_out_value !== want.value) begin
                        $error("out_value mismatch: expected %0d, actual %0d",
                               want.value, m_out_value);
                        err_cnt++;
                    end
                    if (m_in_window !== want.in_win) begin
                        $error("in_window mismatch: expected %0d, actual %0d",
                               want.in_win, m_in_window);
                        err_cnt++;
                    end
                    if (want.in_win)
                        inwin_cnt++;
                end
                checked_cnt++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_cnt, predicted_px_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_pixel(int px, int py, int pv, int cx, int cy, int peak);
        spot_pixel_t r;
        r.px   = CW'(px);
        r.py   = CW'(py);
        r.pv   = VW'(pv);
        r.cx   = FW'(cx);
        r.cy   = FW'(cy);
        r.peak = PW'(peak);
        pixel_feed_q.push_back(r);
    endtask

    // Wait until every queued pixel is out and every result is back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pixel_feed_q.size() != 0 || s_valid || predicted_px_q.size() != 0);
    endtask

    // One max_level transaction; the block is idle when this is called
    task automatic write_ceiling(logic [VW-1:0] level);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        ceiling_adu = level;
        setting_cnt++;
    endtask

    // Stimulus sequence
    initial begin
        int cell_x;
        int cell_y;
        int tx;
        int ty;
        int pv;
        int peak;
        int sel;
        logic [VW-1:0] level;

        for (int k = 0; k < LUT_DEPTH; k++)
            psf_weight_lut[k] = psf_weight(k);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset ceiling of 1023
        queue_pixel(100, 200, 100, 100 << 8, 200 << 8, 50 << 4);       // spot centre
        queue_pixel(0, 0, 0, 0, 0, 0);                                   // all zero
        queue_pixel(0, 11, 7, 3 * 256 + 128, 3 * 256 + 128, 4000);      // window clipped at 0
        queue_pixel(0, 12, 7, 3 * 256 + 128, 3 * 256 + 128, 4000);      // just past the top edge
        queue_pixel(92, 50, 20, 100 * 256 + 192, 50 << 8, 9000);        // left edge
        queue_pixel(91, 50, 20, 100 * 256 + 192, 50 << 8, 9000);        // one left of it
        queue_pixel(108, 50, 20, 100 * 256 + 192, 50 << 8, 9000);       // right edge
        queue_pixel(109, 50, 20, 100 * 256 + 192, 50 << 8, 9000);       // one right of it
        queue_pixel(3000, 10, 65535, 500 << 8, 10 << 8, 1000);          // pass-through above ceiling
        queue_pixel(40, 40, 1000, 40 << 8, 40 << 8, 262143);            // saturates
        queue_pixel(40, 40, 5, 40 << 8, 40 << 8, -262144);              // negative sum
        queue_pixel(COORD_MAX, COORD_MAX, 321, (1 << FW) - 1, (1 << FW) - 1, 1000);
        queue_pixel(COORD_MAX, 0, 77, 0, 0, 500);                        // far corner
        queue_pixel(0, COORD_MAX, 88, (1 << FW) - 1, (1 << FW) - 1, 500);
        queue_pixel(1008, 2000, 900, 1000 << 8, 2000 << 8, -262144);    // window rim, deep peak
        wait_drained();

        // Directed: zero ceiling
        write_ceiling(16'd0);
        queue_pixel(10, 10, 0, 10 << 8, 10 << 8, 16);
        queue_pixel(10, 10, 0, 10 << 8, 10 << 8, 0);
        queue_pixel(10, 30, 65535, 10 << 8, 10 << 8, 16);
        wait_drained();

        // Directed: full-scale ceiling
        write_ceiling(16'hFFFF);
        queue_pixel(7, 9, 65535, 7 << 8, 9 << 8, 262143);
        queue_pixel(7, 9, 60000, 7 << 8, 9 << 8, 1000);
        queue_pixel(7, 9, 65535, 7 << 8, 9 << 8, -16);
        queue_pixel(12, 13, 32768, 7 * 256 + 100, 9 * 256 + 200, -3000);
        wait_drained();

        // Random phases, each writing a ceiling and setting an idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0, 5:    level = 16'hFFFF;
                2:       level = gspi_pkg::MAX_LEVEL_RESET;
                3:       level = 16'd0;
                4:       level = VW'($urandom_range(1, 4000));
                7:       level = VW'($urandom_range(0, 2047));
                default: level = VW'($urandom_range(1, 65534));
            endcase
            write_ceiling(level);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(99);
                pv  = ($urandom_range(1) != 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 2000);
                peak = ($urandom_range(1) != 0) ? $urandom_range(0, (1 << PW) - 1)
                                                : int'($urandom_range(0, 16383)) - 8192;
                if (sel < 20) begin
                    // noise: anything at all, mostly outside the window
                    queue_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                pv, $urandom_range(0, (1 << FW) - 1),
                                $urandom_range(0, (1 << FW) - 1), peak);
                end else begin
                    // pixel near a spot, often near the frame border
                    if (sel < 35) begin
                        cell_x = ($urandom_range(1) != 0) ? $urandom_range(0, 10)
                                                          : $urandom_range(COORD_MAX - 10,
                                                                           COORD_MAX);
                        cell_y = $urandom_range(0, COORD_MAX);
                    end else begin
                        cell_x = $urandom_range(0, COORD_MAX);
                        cell_y = ($urandom_range(3) == 0) ? $urandom_range(0, 10)
                                                          : $urandom_range(0, COORD_MAX);
                    end
                    tx = cell_x + int'($urandom_range(0, 20)) - 10;
                    ty = cell_y + int'($urandom_range(0, 20)) - 10;
                    tx = (tx < 0) ? 0 : (tx > COORD_MAX) ? COORD_MAX : tx;
                    ty = (ty < 0) ? 0 : (ty > COORD_MAX) ? COORD_MAX : ty;
                    queue_pixel(tx, ty, pv,
                                (cell_x << gspi_pkg::FRAC_BITS) | $urandom_range(0, 255),
                                (cell_y << gspi_pkg::FRAC_BITS) | $urandom_range(0, 255),
                                peak);
                end
            end
            wait_drained();
        end

        // Let any stray transaction show up before the verdict
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (predicted_px_q.size() != 0) begin
            $error("%0d expected results never arrived", predicted_px_q.size());
            err_cnt++;
        end

        $display("Run covered %0d pixel transactions under %0d max_level settings,",
                 sent_cnt, setting_cnt);
        $display("with %0d results checked, %0d of them inside a spot window.",
                 checked_cnt, inwin_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gspi_pkg.sv
hw/rtl/gspi_profile_rom.sv
hw/rtl/gaussian_spot_pixel_injector_core.sv
hw/rtl/gspi_checker.sv
sim/tb_top.sv
